// ----- src/pnelg_pkg.sv -----
// Package for the PN early/late generator: register indexes, reset values,
// widths and the control word shared by the delay line cells. No dependencies.
package pnelg_pkg;

  localparam int LINE_DEPTH_DEF = 64;   // default number of delay line cells
  localparam int MAX_DELAY      = 32;   // upper bound on the tap spacing
  localparam int MAX_LENGTH     = 32;   // upper bound on the LFSR length
  localparam int LEN_LIM        = (MAX_LENGTH < 32) ? MAX_LENGTH : 32;

  localparam int CFG_W   = 32;          // widest register
  localparam int IDX_W   = 3;           // register index width
  localparam int SMALL_W = 6;           // delay and length register width
  localparam int LEVEL_W = 16;
  localparam int LFSR_W  = 33;
  localparam int POS_W   = 7;           // holds any line position up to 2*MAX_DELAY

  typedef enum logic [IDX_W-1:0] {
    REG_DELAY  = 3'd0,
    REG_LENGTH = 3'd1,
    REG_SEED   = 3'd2,
    REG_TAPS   = 3'd3,
    REG_HIGH   = 3'd4,
    REG_LOW    = 3'd5
  } reg_index_t;

  localparam logic [SMALL_W-1:0] DELAY_RST  = 6'd4;
  localparam logic [SMALL_W-1:0] LENGTH_RST = 6'd7;
  localparam logic [31:0]        SEED_RST   = 32'd12;
  localparam logic [31:0]        TAPS_RST   = 32'd0;
  localparam logic signed [LEVEL_W-1:0] HIGH_RST = 16'sd16384;
  localparam logic signed [LEVEL_W-1:0] LOW_RST  = -16'sd16384;

  // Control word broadcast to every delay line cell
  typedef struct packed {
    logic             advance;   // a word is accepted this cycle
    logic [POS_W-1:0] total;     // active line length, 2*delay
    logic [POS_W-1:0] ref_pos;   // delay-1
    logic [POS_W-1:0] late_pos;  // 2*delay-1
  } line_ctrl_t;

endpackage

// ----- src/pnelg_line_cell.sv -----
// One cell of the early/late delay line: holds a single PN bit and flags
// whether it sits on the reference or late tap. Depends on pnelg_pkg.
module pnelg_line_cell #(
  parameter int INDEX = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  pnelg_pkg::line_ctrl_t ctrl,
  input  logic                  shift_in,
  output logic                  stored,
  output logic                  ref_hit,
  output logic                  late_hit
);
  import pnelg_pkg::*;

  localparam logic [POS_W-1:0] POS = POS_W'(INDEX);

  // cells past the active length hold their value
  always_ff @(posedge clk) begin
    if (rst) begin
      stored <= 1'b0;
    end else if (ctrl.advance && (POS < ctrl.total)) begin
      stored <= shift_in;
    end
  end

  assign ref_hit  = stored && (POS == ctrl.ref_pos);
  assign late_hit = stored && (POS == ctrl.late_pos);

endmodule

// ----- src/pnelg_lfsr.sv -----
// Fibonacci LFSR with rising-edge detection on the sampled clock level.
// Depends on pnelg_pkg.
module pnelg_lfsr (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic                          clock_level,
  input  logic [pnelg_pkg::SMALL_W-1:0] length,
  input  logic [31:0]                   tap_mask,
  input  logic                          seed_load,
  input  logic [31:0]                   seed,
  output logic                          rise,
  output logic                          pn_bit
);
  import pnelg_pkg::*;

  logic [LFSR_W-1:0] lfsr;
  logic [LFSR_W-1:0] lfsr_next;
  logic              previous_clock;
  logic [31:0]       len_mask;
  logic              parity;

  always_comb begin
    for (int i = 0; i < 32; i++) begin
      len_mask[i] = (SMALL_W'(i) < length);
    end
  end

  assign parity    = ^(lfsr[31:0] & tap_mask & len_mask);
  assign lfsr_next = {lfsr[31:0], parity};
  assign rise      = !previous_clock && clock_level;
  assign pn_bit    = lfsr_next[length];

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr           <= {1'b0, SEED_RST};
      previous_clock <= 1'b0;
    end else begin
      if (seed_load) begin
        lfsr <= {1'b0, seed};
      end else if (advance && rise) begin
        lfsr <= lfsr_next;
      end
      if (advance) begin
        previous_clock <= clock_level;
      end
    end
  end

endmodule

// ----- src/pn_early_late_generator_unit.sv -----
// PN early/late generator, top level: configuration registers, LFSR and a
// row of delay line cells. Depends on pnelg_pkg, pnelg_lfsr, pnelg_line_cell.
// Each word out is registered and appears in the cycle after its clock sample word is accepted.
// Throughput: one word per cycle while the output is not stalled; the cells and the LFSR update in one step.
// Reset: registers take their default values, the LFSR loads the default
// seed, the previous clock sample and every delay line cell clear to zero.
module pn_early_late_generator_unit #(
  parameter int LINE_DEPTH = pnelg_pkg::LINE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // sample input
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               clock_level,
  // early / reference / late output
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [pnelg_pkg::LEVEL_W-1:0] early_out,
  output logic signed [pnelg_pkg::LEVEL_W-1:0] reference_out,
  output logic signed [pnelg_pkg::LEVEL_W-1:0] late_out,
  // configuration writes
  input  logic                               cfg_write,
  input  logic [pnelg_pkg::IDX_W-1:0]        cfg_index,
  input  logic [pnelg_pkg::CFG_W-1:0]        cfg_data
);
  import pnelg_pkg::*;

  // tap spacing bound: the line must hold two spacings
  localparam int DELAY_LIM = (MAX_DELAY < LINE_DEPTH / 2) ? MAX_DELAY : LINE_DEPTH / 2;

  // configuration registers; the seed lives only in the LFSR itself
  logic [SMALL_W-1:0]        delay_each_way;
  logic [SMALL_W-1:0]        register_length;
  logic [31:0]               tap_mask;
  logic signed [LEVEL_W-1:0] high_level;
  logic signed [LEVEL_W-1:0] low_level;

  logic                      accept;
  logic                      seed_load;
  logic [SMALL_W-1:0]        active_delay;
  logic [SMALL_W-1:0]        active_length;
  logic                      rise;
  logic                      pn_bit;
  logic                      head;
  line_ctrl_t                ctrl;
  logic [LINE_DEPTH-1:0]     stored;
  logic [LINE_DEPTH-1:0]     ref_hits;
  logic [LINE_DEPTH-1:0]     late_hits;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_each_way  <= DELAY_RST;
      register_length <= LENGTH_RST;
      tap_mask        <= TAPS_RST;
      high_level      <= HIGH_RST;
      low_level       <= LOW_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DELAY:  delay_each_way  <= cfg_data[SMALL_W-1:0];
        REG_LENGTH: register_length <= cfg_data[SMALL_W-1:0];
        REG_SEED:   ;  // loaded straight into the LFSR
        REG_TAPS:   tap_mask        <= cfg_data;
        REG_HIGH:   high_level      <= cfg_data[LEVEL_W-1:0];
        REG_LOW:    low_level       <= cfg_data[LEVEL_W-1:0];
        default:    ;  // unused indexes: drop the write
      endcase
    end
  end

  // a seed write also reloads the shift register at once
  assign seed_load = cfg_write && (cfg_index == REG_SEED);

  // clamp delay to 1..DELAY_LIM and length to LEN_LIM
  always_comb begin
    priority if (delay_each_way == '0) begin
      active_delay = SMALL_W'(1);
    end else if (delay_each_way > SMALL_W'(DELAY_LIM)) begin
      active_delay = SMALL_W'(DELAY_LIM);
    end else begin
      active_delay = delay_each_way;
    end
    if (register_length > SMALL_W'(LEN_LIM)) begin
      active_length = SMALL_W'(LEN_LIM);
    end else begin
      active_length = register_length;
    end
  end

  // Single output stage: take a new sample whenever the held word is gone
  // or leaves this cycle. The cells only move on an accepted sample, so the
  // taps hold steady while the output stalls.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  pnelg_lfsr u_lfsr (
    .clk         (clk),
    .rst         (rst),
    .advance     (accept),
    .clock_level (clock_level),
    .length      (active_length),
    .tap_mask    (tap_mask),
    .seed_load   (seed_load),
    .seed        (cfg_data),
    .rise        (rise),
    .pn_bit      (pn_bit)
  );

  // head of the line: new PN bit on a rising edge, otherwise hold
  assign head = rise ? pn_bit : stored[0];

  always_comb begin
    ctrl.advance  = accept;
    ctrl.total    = {active_delay, 1'b0};
    ctrl.ref_pos  = POS_W'(active_delay) - POS_W'(1);
    ctrl.late_pos = {active_delay, 1'b0} - POS_W'(1);
  end

  // row of cells, each active cell handing its bit to the next on every accepted sample
  for (genvar g = 0; g < LINE_DEPTH; g++) begin : g_cell
    logic shift_in;
    if (g == 0) begin : g_head
      assign shift_in = head;
    end else begin : g_link
      assign shift_in = stored[g-1];
    end
    pnelg_line_cell #(
      .INDEX (g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .shift_in (shift_in),
      .stored   (stored[g]),
      .ref_hit  (ref_hits[g]),
      .late_hit (late_hits[g])
    );
  end

  // map the three taps to levels
  assign early_out     = stored[0]   ? high_level : low_level;
  assign reference_out = |ref_hits  ? high_level : low_level;
  assign late_out      = |late_hits ? high_level : low_level;

  // an accepted sample always yields a word in the next cycle
  a_accept_gives_word: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted sample produced no output word");

  // on a rising edge the early tap shows the fresh PN bit
  a_edge_loads_head: assert property (@(posedge clk) disable iff (rst)
    (accept && rise && !seed_load) |=> (stored[0] == $past(pn_bit)))
    else $error("early tap did not take the new PN bit");

  // without an edge the head of the line holds
  a_head_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && !rise) |=> $stable(stored[0]))
    else $error("head of delay line changed without a clock edge");

  // the reference and late taps never select more than one cell each
  a_single_tap: assert property (@(posedge clk) disable iff (rst)
    $onehot0(ref_hits) && $onehot0(late_hits))
    else $error("tap selects more than one delay line cell");

endmodule
